// ===== sv/ftn_pkg.sv =====
// Shared types, constants and the fingering-to-note table for the fingering converter.
// Has no dependencies. Every other file in the sv folder imports it.
package ftn_pkg;

   // Field widths.
   localparam int PATTERN_W = 6;
   localparam int TICKS_W   = 32;
   localparam int NOTE_W    = 7;
   localparam int RAW_W     = 6;
   localparam int UNIT_W    = 8;
   localparam int INTVL_W   = 6;
   localparam int LEVEL_W   = 2;
   localparam int LIMIT_W   = UNIT_W + LEVEL_W;

   // Configuration port shape.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_DEAD_BAND_UNIT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_WIDE_INTERVAL  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MID_INTERVAL   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SMALL_INTERVAL = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_NOTE_OFFSET    = 3'd4;

   // Register reset values.
   localparam logic [UNIT_W-1:0]  RST_DEAD_BAND_UNIT = 8'd5;
   localparam logic [INTVL_W-1:0] RST_WIDE_INTERVAL  = 6'd12;
   localparam logic [INTVL_W-1:0] RST_MID_INTERVAL   = 6'd9;
   localparam logic [INTVL_W-1:0] RST_SMALL_INTERVAL = 6'd3;
   localparam logic [NOTE_W-1:0]  RST_NOTE_OFFSET    = 7'd60;

   // Deadband levels.
   localparam logic [LEVEL_W-1:0] LEVEL_NONE  = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_SMALL = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_MID   = 2'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_WIDE  = 2'd3;

   // Raw note held when no sensor is touched, and the top MIDI note.
   localparam logic [RAW_W-1:0]  NOTE_IDLE = 6'h24;
   localparam logic [NOTE_W-1:0] NOTE_MAX  = 7'd127;

   // Configuration register bank as seen by the engine.
   typedef struct packed {
      logic [UNIT_W-1:0]  dead_band_unit;
      logic [INTVL_W-1:0] wide_interval;
      logic [INTVL_W-1:0] mid_interval;
      logic [INTVL_W-1:0] small_interval;
      logic [NOTE_W-1:0]  note_offset;
   } cfg_type;

   // Result of one poll.
   typedef struct packed {
      logic [NOTE_W-1:0] note_value;
      logic              key_on;
   } result_type;

   // Fingering table: sensor pattern to raw note.
   function automatic logic [RAW_W-1:0] note_rom(input logic [PATTERN_W-1:0] pat);
      logic [RAW_W-1:0] n;
      begin
         case (pat)
            6'd0:  n = 6'h24;  6'd1:  n = 6'h1f;  6'd2:  n = 6'h1d;  6'd3:  n = 6'h21;
            6'd4:  n = 6'h1c;  6'd5:  n = 6'h23;  6'd6:  n = 6'h1a;  6'd7:  n = 6'h18;
            6'd8:  n = 6'h25;  6'd9:  n = 6'h20;  6'd10: n = 6'h1e;  6'd11: n = 6'h20;
            6'd12: n = 6'h1b;  6'd13: n = 6'h22;  6'd14: n = 6'h1b;  6'd15: n = 6'h19;
            6'd16: n = 6'h18;  6'd17: n = 6'h13;  6'd18: n = 6'h11;  6'd19: n = 6'h15;
            6'd20: n = 6'h10;  6'd21: n = 6'h17;  6'd22: n = 6'h0e;  6'd23: n = 6'h0c;
            6'd24: n = 6'h19;  6'd25: n = 6'h14;  6'd26: n = 6'h12;  6'd27: n = 6'h14;
            6'd28: n = 6'h0f;  6'd29: n = 6'h16;  6'd30: n = 6'h0f;  6'd31: n = 6'h0d;
            6'd32: n = 6'h18;  6'd33: n = 6'h13;  6'd34: n = 6'h11;  6'd35: n = 6'h15;
            6'd36: n = 6'h10;  6'd37: n = 6'h17;  6'd38: n = 6'h0e;  6'd39: n = 6'h0c;
            6'd40: n = 6'h19;  6'd41: n = 6'h14;  6'd42: n = 6'h12;  6'd43: n = 6'h14;
            6'd44: n = 6'h0f;  6'd45: n = 6'h16;  6'd46: n = 6'h0f;  6'd47: n = 6'h0d;
            6'd48: n = 6'h0c;  6'd49: n = 6'h07;  6'd50: n = 6'h05;  6'd51: n = 6'h09;
            6'd52: n = 6'h04;  6'd53: n = 6'h0b;  6'd54: n = 6'h02;  6'd55: n = 6'h00;
            6'd56: n = 6'h0d;  6'd57: n = 6'h08;  6'd58: n = 6'h06;  6'd59: n = 6'h08;
            6'd60: n = 6'h03;  6'd61: n = 6'h0a;  6'd62: n = 6'h03;  6'd63: n = 6'h01;
            default: n = NOTE_IDLE;
         endcase
         return n;
      end
   endfunction

endpackage

// ===== sv/ftn_if.sv =====
// Valid/ready channel interfaces for the poll requests and the note results.
// Depends on ftn_pkg for the field widths.
interface ftn_req_if import ftn_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [PATTERN_W-1:0] touch_pattern;
   logic [TICKS_W-1:0]   now_ticks;

   modport source (output valid, output touch_pattern, output now_ticks, input ready);
   modport sink   (input valid, input touch_pattern, input now_ticks, output ready);
endinterface

interface ftn_rsp_if import ftn_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [NOTE_W-1:0] note_value;
   logic              key_on;

   modport source (output valid, output note_value, output key_on, input ready);
   modport sink   (input valid, input note_value, input key_on, output ready);
endinterface

// ===== sv/ftn_csr.sv =====
// Configuration register bank written through the plain csr write port.
// Depends on ftn_pkg for register indexes, reset values and cfg_type.
module ftn_csr import ftn_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the register index; writes beyond the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_DEAD_BAND_UNIT: cfg_in.dead_band_unit = csr_wdata[UNIT_W-1:0];
            REG_WIDE_INTERVAL:  cfg_in.wide_interval  = csr_wdata[INTVL_W-1:0];
            REG_MID_INTERVAL:   cfg_in.mid_interval   = csr_wdata[INTVL_W-1:0];
            REG_SMALL_INTERVAL: cfg_in.small_interval = csr_wdata[INTVL_W-1:0];
            REG_NOTE_OFFSET:    cfg_in.note_offset    = csr_wdata[NOTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dead_band_unit <= RST_DEAD_BAND_UNIT;
         cfg_ff.wide_interval  <= RST_WIDE_INTERVAL;
         cfg_ff.mid_interval   <= RST_MID_INTERVAL;
         cfg_ff.small_interval <= RST_SMALL_INTERVAL;
         cfg_ff.note_offset    <= RST_NOTE_OFFSET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/ftn_engine.sv =====
// Deadband decision logic and the per-poll state it keeps between polls.
// Depends on ftn_pkg for the note table, levels and cfg_type.
module ftn_engine import ftn_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 step,
   input  logic [PATTERN_W-1:0] touch_pattern,
   input  logic [TICKS_W-1:0]   now_ticks,
   output result_type           result
);

   logic [PATTERN_W-1:0] prev_pattern_ff, prev_pattern_in;
   logic [PATTERN_W-1:0] tap_pattern_ff,  tap_pattern_in;
   logic                 tap_armed_ff,    tap_armed_in;
   logic [RAW_W-1:0]     held_note_ff,    held_note_in;
   logic [TICKS_W-1:0]   band_start_ff,   band_start_in;
   logic [LEVEL_W-1:0]   band_level_ff,   band_level_in;

   logic                 same;
   logic [TICKS_W-1:0]   elapsed;
   logic [LIMIT_W-1:0]   band_limit;
   logic                 timed_out;
   logic                 tap_hit;
   logic [RAW_W-1:0]     new_note;
   logic [RAW_W-1:0]     distance;
   logic [LEVEL_W-1:0]   new_level;
   logic                 key_on;
   logic [NOTE_W:0]      offset_sum;
   logic [NOTE_W-1:0]    on_note;

   // Timeout of a running deadband while the pattern holds still.
   always_comb begin
      same       = (touch_pattern == prev_pattern_ff);
      elapsed    = now_ticks - band_start_ff;
      band_limit = LIMIT_W'(cfg.dead_band_unit) * LIMIT_W'(band_level_ff);
      timed_out  = same && (band_level_ff != LEVEL_NONE) && (band_start_ff != '0)
                   && !elapsed[TICKS_W-1] && (elapsed > TICKS_W'(band_limit));
   end

   // A pattern change either returns to an armed tap or picks a new level.
   always_comb begin
      tap_hit  = !same && (band_level_ff != LEVEL_NONE) && tap_armed_ff
                 && (tap_pattern_ff == touch_pattern);
      new_note = note_rom(touch_pattern);
      distance = (new_note > held_note_ff) ? (new_note - held_note_ff)
                                           : (held_note_ff - new_note);
      if (distance >= cfg.wide_interval) begin
         new_level = LEVEL_WIDE;
      end else if (distance >= cfg.mid_interval) begin
         new_level = LEVEL_MID;
      end else if (distance >= cfg.small_interval) begin
         new_level = LEVEL_SMALL;
      end else begin
         new_level = LEVEL_NONE;
      end
      key_on = timed_out || tap_hit || (!same && (new_level == LEVEL_NONE));
   end

   // Reported note: the saturated offset note on key-on, else the held raw note.
   always_comb begin
      offset_sum        = (NOTE_W + 1)'(new_note) + (NOTE_W + 1)'(cfg.note_offset);
      on_note           = offset_sum[NOTE_W] ? NOTE_MAX : offset_sum[NOTE_W-1:0];
      result.key_on     = key_on;
      result.note_value = key_on ? on_note : NOTE_W'(held_note_ff);
   end

   // Next state for the request being processed.
   always_comb begin
      prev_pattern_in = prev_pattern_ff;
      tap_pattern_in  = tap_pattern_ff;
      tap_armed_in    = tap_armed_ff;
      held_note_in    = held_note_ff;
      band_start_in   = band_start_ff;
      band_level_in   = band_level_ff;
      if (step) begin
         if (!same) begin
            prev_pattern_in = touch_pattern;
         end
         if (key_on) begin
            held_note_in   = new_note;
            tap_armed_in   = 1'b0;
            tap_pattern_in = '0;
            band_start_in  = '0;
            band_level_in  = LEVEL_NONE;
         end else if (!same && !tap_hit) begin
            band_start_in = now_ticks;
            band_level_in = new_level;
            // Arm the tap only when some sensor was newly pressed.
            if ((new_level == LEVEL_WIDE)
                && ((touch_pattern & ~prev_pattern_ff) != '0)) begin
               tap_pattern_in = prev_pattern_ff;
               tap_armed_in   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pattern_ff <= '0;
         tap_pattern_ff  <= '0;
         tap_armed_ff    <= 1'b0;
         held_note_ff    <= NOTE_IDLE;
         band_start_ff   <= '0;
         band_level_ff   <= LEVEL_NONE;
      end else begin
         prev_pattern_ff <= prev_pattern_in;
         tap_pattern_ff  <= tap_pattern_in;
         tap_armed_ff    <= tap_armed_in;
         held_note_ff    <= held_note_in;
         band_start_ff   <= band_start_in;
         band_level_ff   <= band_level_in;
      end
   end

endmodule

// ===== sv/fingering_to_note_with_deadband.sv =====
// Fingering-to-note converter with interval-dependent deadband. Each request carries a
// 6-bit touch pattern and a 32-bit tick timestamp and yields exactly one response with a
// note and a key-on flag. One request is taken every clock cycle unless the response
// register is stalled; each request passes through the input register and then the
// response register. The rate is set by the deadband state update, which finishes for
// each request between those two registers. req ready follows rsp ready
// combinationally while the input and response registers are both full. Configuration
// registers are written through the csr port and must only change while no request is
// in flight.
module fingering_to_note_with_deadband import ftn_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   ftn_req_if.sink                req_bus,
   ftn_rsp_if.source              rsp_bus,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type              cfg;
   result_type           result;

   logic                 in_valid_ff, in_valid_in;
   logic [PATTERN_W-1:0] in_pattern_ff;
   logic [TICKS_W-1:0]   in_ticks_ff;
   logic                 out_valid_ff, out_valid_in;
   result_type           out_result_ff;

   logic                 advance;
   logic                 req_fire;

   ftn_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ftn_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .step          (advance),
      .touch_pattern (in_pattern_ff),
      .now_ticks     (in_ticks_ff),
      .result        (result)
   );

   // Handshake: the input stage moves on whenever the response register is free.
   always_comb begin
      advance         = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
      req_bus.ready   = !in_valid_ff || advance;
      req_fire        = req_bus.valid && req_bus.ready;
      in_valid_in     = req_fire || (in_valid_ff && !advance);
      out_valid_in    = advance || (out_valid_ff && !rsp_bus.ready);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_pattern_ff <= req_bus.touch_pattern;
         in_ticks_ff   <= req_bus.now_ticks;
      end
      if (advance) begin
         out_result_ff <= result;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.note_value = out_result_ff.note_value;
   assign rsp_bus.key_on     = out_result_ff.key_on;

endmodule

// ===== sv/ftn_checker.sv =====
// Port-level checks for the fingering converter, bound to its top level.
// Depends on ftn_pkg for the field widths.
module ftn_checker import ftn_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [NOTE_W-1:0] note_value,
   input logic              key_on
);

   localparam logic [NOTE_W-1:0] RAW_NOTE_TOP = 7'd37;

   // A stalled response keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(note_value) && $stable(key_on))
      else $error("stalled response changed");

   // Without a key-on the note is a raw table note.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !key_on |-> note_value <= RAW_NOTE_TOP)
      else $error("raw note out of table range");

   // No response is pending right after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response pending after reset");

   // A new response always follows an accepted request through the input register.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without a matching request");

endmodule

bind fingering_to_note_with_deadband ftn_checker u_ftn_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .note_value (rsp_bus.note_value),
   .key_on     (rsp_bus.key_on)
);

// ===== verif/note_scoreboard.sv =====
`timescale 1ns / 100ps
// Scoreboard for the fingering-to-note converter: predicts the note of every accepted poll
// request and checks the responses against those predictions in order.
// Depends on ftn_pkg and on the channel interfaces in ftn_if.sv.
module note_scoreboard import ftn_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   ftn_req_if                     req_mon,
   ftn_rsp_if                     rsp_mon,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     failures,
   output int                     outstanding,
   output int                     polls_seen,
   output int                     key_ons_seen
);

   // Fingering chart: touch pattern to raw note.
   localparam logic [RAW_W-1:0] FINGER_TABLE [64] = '{
      6'h24, 6'h1f, 6'h1d, 6'h21, 6'h1c, 6'h23, 6'h1a, 6'h18,
      6'h25, 6'h20, 6'h1e, 6'h20, 6'h1b, 6'h22, 6'h1b, 6'h19,
      6'h18, 6'h13, 6'h11, 6'h15, 6'h10, 6'h17, 6'h0e, 6'h0c,
      6'h19, 6'h14, 6'h12, 6'h14, 6'h0f, 6'h16, 6'h0f, 6'h0d,
      6'h18, 6'h13, 6'h11, 6'h15, 6'h10, 6'h17, 6'h0e, 6'h0c,
      6'h19, 6'h14, 6'h12, 6'h14, 6'h0f, 6'h16, 6'h0f, 6'h0d,
      6'h0c, 6'h07, 6'h05, 6'h09, 6'h04, 6'h0b, 6'h02, 6'h00,
      6'h0d, 6'h08, 6'h06, 6'h08, 6'h03, 6'h0a, 6'h03, 6'h01
   };

   // Local copy of the register bank and of the deadband state.
   cfg_type              bank;
   logic [PATTERN_W-1:0] last_pattern;
   logic [PATTERN_W-1:0] tap_target;
   logic                 tap_set;
   logic [RAW_W-1:0]     held_raw;
   logic [TICKS_W-1:0]   band_t0;
   logic [LEVEL_W-1:0]   band_lvl;

   result_type expected_notes [$];
   int         mismatches;
   int         polls;
   int         key_ons;

   // Key-on: latch the new raw note, drop any deadband and tap, and return the offset note.
   function automatic logic [NOTE_W-1:0] strike_note(input logic [PATTERN_W-1:0] pat);
      logic [NOTE_W:0] sum;
      held_raw   = FINGER_TABLE[pat];
      tap_set    = 1'b0;
      tap_target = '0;
      band_t0    = '0;
      band_lvl   = LEVEL_NONE;
      sum = {2'b00, held_raw} + {1'b0, bank.note_offset};
      return (sum > {1'b0, NOTE_MAX}) ? NOTE_MAX : sum[NOTE_W-1:0];
   endfunction

   // Advance the deadband state by one poll and work out the response it produces.
   task automatic predict_note(input logic [PATTERN_W-1:0] pat, input logic [TICKS_W-1:0] now,
                               output result_type res);
      logic [TICKS_W-1:0] elapsed;
      logic [LIMIT_W-1:0] hold_limit;
      logic [RAW_W-1:0]   target;
      logic [RAW_W-1:0]   interval;
      res.note_value = {1'b0, held_raw};
      res.key_on     = 1'b0;
      if (pat == last_pattern) begin
         // A stable pattern keys on once it outlasts the deadband. A start time of zero
         // never times out, and a negative elapsed time never does either.
         if (band_lvl != LEVEL_NONE && band_t0 != '0) begin
            elapsed    = now - band_t0;
            hold_limit = bank.dead_band_unit * band_lvl;
            if (!elapsed[TICKS_W-1] && elapsed > hold_limit) begin
               res.note_value = strike_note(pat);
               res.key_on     = 1'b1;
            end
         end
      end else begin
         if (band_lvl != LEVEL_NONE && tap_set && tap_target == pat) begin
            // Returning to the armed tap pattern keys on at once.
            res.note_value = strike_note(pat);
            res.key_on     = 1'b1;
         end else begin
            // The interval to the held note picks the level; wide is tested first.
            target   = FINGER_TABLE[pat];
            interval = (target > held_raw) ? target - held_raw : held_raw - target;
            if (interval >= bank.wide_interval) begin
               band_t0  = now;
               band_lvl = LEVEL_WIDE;
               if (((pat ^ last_pattern) & pat) != '0) begin
                  tap_target = last_pattern;
                  tap_set    = 1'b1;
               end
            end else if (interval >= bank.mid_interval) begin
               band_t0  = now;
               band_lvl = LEVEL_MID;
            end else if (interval >= bank.small_interval) begin
               band_t0  = now;
               band_lvl = LEVEL_SMALL;
            end else begin
               res.note_value = strike_note(pat);
               res.key_on     = 1'b1;
            end
         end
         last_pattern = pat;
      end
   endtask

   // Track register writes, check each response, then predict each new request.
   always @(posedge clock) begin : watch
      result_type want;
      result_type made;
      if (reset) begin
         bank.dead_band_unit = RST_DEAD_BAND_UNIT;
         bank.wide_interval  = RST_WIDE_INTERVAL;
         bank.mid_interval   = RST_MID_INTERVAL;
         bank.small_interval = RST_SMALL_INTERVAL;
         bank.note_offset    = RST_NOTE_OFFSET;
         last_pattern = '0;
         tap_target   = '0;
         tap_set      = 1'b0;
         held_raw     = NOTE_IDLE;
         band_t0      = '0;
         band_lvl     = LEVEL_NONE;
         expected_notes.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_DEAD_BAND_UNIT: bank.dead_band_unit = csr_wdata[UNIT_W-1:0];
               REG_WIDE_INTERVAL:  bank.wide_interval  = csr_wdata[INTVL_W-1:0];
               REG_MID_INTERVAL:   bank.mid_interval   = csr_wdata[INTVL_W-1:0];
               REG_SMALL_INTERVAL: bank.small_interval = csr_wdata[INTVL_W-1:0];
               REG_NOTE_OFFSET:    bank.note_offset    = csr_wdata[NOTE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_notes.size() == 0) begin
               $error("note response with no poll outstanding: note_value %0d key_on %0d",
                      rsp_mon.note_value, rsp_mon.key_on);
               mismatches++;
            end else begin
               want = expected_notes.pop_front();
               if (rsp_mon.note_value !== want.note_value) begin
                  $error("note_value: expected %0d, got %0d", want.note_value,
                         rsp_mon.note_value);
                  mismatches++;
               end
               if (rsp_mon.key_on !== want.key_on) begin
                  $error("key_on: expected %0d, got %0d", want.key_on, rsp_mon.key_on);
                  mismatches++;
               end
               if (want.key_on) key_ons++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_note(req_mon.touch_pattern, req_mon.now_ticks, made);
            expected_notes.push_back(made);
            polls++;
         end
      end
      outstanding  <= expected_notes.size();
      failures     <= mismatches;
      polls_seen   <= polls;
      key_ons_seen <= key_ons;
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Top of the fingering-to-note testbench: clock, reset, poll stimulus, response back-pressure
// and the verdict. Depends on ftn_pkg, ftn_if.sv, the converter and note_scoreboard.
module testbench import ftn_pkg::*;;

   localparam int PHASES      = 6;
   localparam int HOLD_CYCLES = 48;
   localparam int STALL_LIMIT = 1000;

   // Directed polls, run with the reset register values.
   localparam logic [PATTERN_W-1:0] DIRECTED_PAT [24] = '{
      6'd0,  6'd63, 6'd63, 6'd0,  6'd63, 6'd63, 6'd63, 6'd0,
      6'd0,  6'd0,  6'd0,  6'd8,  6'd1,  6'd1,  6'd1,  6'd19,
      6'd19, 6'd19, 6'd55, 6'd16, 6'd19, 6'd63, 6'd63, 6'd0
   };
   localparam logic [TICKS_W-1:0] DIRECTED_TICK [24] = '{
      // Idle poll, then a wide jump started at time zero that never times out,
      // ended by tapping back to the empty pattern.
      32'd0,         32'd0,         32'd5000,      32'd5001,
      // Wide jump that times out one tick past its limit.
      32'd100,       32'd115,       32'd116,
      // Release without a new press; time running backward, then a positive
      // elapsed time of 0x7FFFFF7F.
      32'd200,       32'd100,       32'hFFFF_FFFF, 32'h8000_0047,
      // Immediate key-on, then a one-unit deadband and a two-unit deadband.
      32'd300,       32'd400,       32'd405,       32'd406,
      32'd500,       32'd510,       32'd511,
      // Tap armed by a wide jump survives a small change and fires on return.
      32'd600,       32'd601,       32'd602,
      // Deadband that starts just before the counter wraps and ends after it.
      32'hFFFF_FFF0, 32'h0000_0010, 32'h0000_0011
   };

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int                     failures;
   int                     outstanding;
   int                     polls_seen;
   int                     key_ons_seen;
   int                     long_holds;
   int                     holds_asked;

   bit                     send_idle;
   bit                     take_idle;
   logic [UNIT_W-1:0]      unit_now;
   logic [PATTERN_W-1:0]   cur_pat;
   logic [PATTERN_W-1:0]   alt_pat;
   logic [TICKS_W-1:0]     tick;

   ftn_req_if req_bus ();
   ftn_rsp_if rsp_bus ();

   fingering_to_note_with_deadband DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   note_scoreboard scoreboard (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .failures     (failures),
      .outstanding  (outstanding),
      .polls_seen   (polls_seen),
      .key_ons_seen (key_ons_seen)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Offer one poll request, after a random pause while send_idle is set, and hold it until it is taken.
   task automatic send_poll(input logic [PATTERN_W-1:0] pat, input logic [TICKS_W-1:0] now);
      int pause;
      pause = send_idle ? $urandom_range(0, 11) : 0;
      if (pause > 0) begin
         req_bus.valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.touch_pattern <= pat;
      req_bus.now_ticks     <= now;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Wait until every predicted response has come back.
   task automatic wait_drained();
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Write the whole register bank, one register per cycle.
   task automatic write_bank(input logic [CSR_DATA_W-1:0] unit, input logic [CSR_DATA_W-1:0] wide,
                             input logic [CSR_DATA_W-1:0] mid, input logic [CSR_DATA_W-1:0] small_iv,
                             input logic [CSR_DATA_W-1:0] offset);
      logic [CSR_INDEX_W-1:0] index [5];
      logic [CSR_DATA_W-1:0]  value [5];
      index = '{REG_DEAD_BAND_UNIT, REG_WIDE_INTERVAL, REG_MID_INTERVAL,
                REG_SMALL_INTERVAL, REG_NOTE_OFFSET};
      value = '{unit, wide, mid, small_iv, offset};
      unit_now = unit;
      for (int k = 0; k < 5; k++) begin
         csr_we    <= 1'b1;
         csr_index <= index[k];
         csr_wdata <= value[k];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Mostly playing-like sequences: held fingerings with time creeping past the deadband,
   // jumps, taps back, single-finger changes; the rest is noise and odd timestamps.
   task automatic play_random(input int count, input int pressure_at);
      int                   pick;
      logic [PATTERN_W-1:0] swap;
      for (int i = 0; i < count; i++) begin
         if (i % 64 == 0) send_idle = ($urandom_range(0, 2) != 0);
         if (i == pressure_at) holds_asked++;
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            tick += $urandom_range(0, unit_now * 3 + 2);
         end else if (pick < 68) begin
            alt_pat = cur_pat;
            cur_pat = PATTERN_W'($urandom);
            tick += $urandom_range(0, 4);
         end else if (pick < 80) begin
            swap    = cur_pat;
            cur_pat = alt_pat;
            alt_pat = swap;
            tick += $urandom_range(0, 3);
         end else if (pick < 88) begin
            alt_pat = cur_pat;
            cur_pat = cur_pat ^ (6'd1 << $urandom_range(0, PATTERN_W - 1));
            tick += $urandom_range(0, 4);
         end else if (pick < 92) begin
            // New fingering started at time zero.
            alt_pat = cur_pat;
            cur_pat = PATTERN_W'($urandom);
            tick = '0;
         end else if (pick < 96) begin
            cur_pat = PATTERN_W'($urandom);
            tick = $urandom;
         end else begin
            tick -= $urandom_range(1, 60);
         end
         send_poll(cur_pat, tick);
      end
   endtask

   // Response side: random pauses, calm stretches, and a long hold-off when asked.
   initial begin : response_sink
      int pause;
      int served;
      served     = 0;
      long_holds = 0;
      take_idle  = 1'b1;
      rsp_bus.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (served % 40 == 0) take_idle = ($urandom_range(0, 2) != 0);
         pause = take_idle ? $urandom_range(0, 11) : 0;
         if (long_holds < holds_asked) begin
            pause += HOLD_CYCLES;
            long_holds++;
         end
         if (pause > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         served++;
      end
   end

   // End the run if no request, response or register write moves for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || csr_we)
            quiet = 0;
         else
            quiet++;
      end
      $display("testbench failed");
      $finish;
   end

   // Stimulus: directed polls, then random phases under different register settings.
   initial begin : stimulus
      logic [CSR_DATA_W-1:0] lo;
      logic [CSR_DATA_W-1:0] md;
      req_bus.valid         <= 1'b0;
      req_bus.touch_pattern <= '0;
      req_bus.now_ticks     <= '0;
      csr_we                <= 1'b0;
      csr_index             <= REG_DEAD_BAND_UNIT;
      csr_wdata             <= '0;
      send_idle    = 1'b1;
      holds_asked  = 0;
      unit_now     = RST_DEAD_BAND_UNIT;
      cur_pat      = '0;
      alt_pat      = '0;
      tick         = 32'd1000;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 24; i++) send_poll(DIRECTED_PAT[i], DIRECTED_TICK[i]);
      play_random(190, 120);

      for (int phase = 1; phase < PHASES; phase++) begin
         req_bus.valid <= 1'b0;
         wait_drained();
         case (phase)
            // Every change is a wide jump, the deadband is zero and the offset saturates.
            1: write_bank(8'd0, 8'd0, 8'd0, 8'd0, 8'd127);
            // Longest deadband unit, wide and mid out of reach, no offset.
            2: write_bank(8'd255, 8'd63, 8'd63, 8'd5, 8'd0);
            // Thresholds out of order: the wide one wins before the others are tried.
            3: write_bank(8'd2, 8'd4, 8'd10, 8'd63, 8'd100);
            default: begin
               lo = CSR_DATA_W'($urandom_range(0, 10));
               md = lo + CSR_DATA_W'($urandom_range(0, 12));
               write_bank(CSR_DATA_W'($urandom_range(0, 12)),
                          md + CSR_DATA_W'($urandom_range(0, 20)), md, lo,
                          CSR_DATA_W'($urandom_range(0, 127)));
            end
         endcase
         play_random(210, (phase % 2 == 0) ? 80 : -1);
      end

      req_bus.valid <= 1'b0;
      wait_drained();
      repeat (8) @(posedge clock);
      $display("Checked %0d poll requests over %0d register settings, %0d of them key-ons.",
               polls_seen, PHASES, key_ons_seen);
      $display("The response side held off %0d times for %0d cycles to back up the requests.",
               long_holds, HOLD_CYCLES);
      if (failures == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
